### hdl/epf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Ethernet protocol filter package
// Shared types, protocol constants, filter mode codes and the layer-4
// offset function used by the parser and the classifier.
// ----------------------------------------------------------------------------
package epf_pkg;

    localparam logic [15:0] TYPE_IPV4 = 16'h0800;
    localparam logic [15:0] TYPE_ARP  = 16'h0806;
    localparam logic [15:0] TYPE_IPV6 = 16'h86DD;

    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam logic [7:0] PROTO_UDP = 8'd17;

    localparam logic [15:0] PORT_HTTP  = 16'd80;
    localparam logic [15:0] PORT_HTTPS = 16'd443;
    localparam logic [15:0] PORT_DNS   = 16'd53;

    localparam logic [6:0] ETH_LEN   = 7'd14;
    localparam logic [6:0] IPV6_L4   = 7'd54;
    localparam logic [6:0] POS_MAX   = 7'd127;
    localparam logic [6:0] POS_TYPE_HI = 7'd12;
    localparam logic [6:0] POS_TYPE_LO = 7'd13;
    localparam logic [6:0] POS_IHL     = 7'd14;
    localparam logic [6:0] POS_PROTO_V4 = 7'd23;
    localparam logic [6:0] POS_NEXT_V6  = 7'd20;

    localparam logic [2:0] MODE_HTTP  = 3'd0;
    localparam logic [2:0] MODE_HTTPS = 3'd1;
    localparam logic [2:0] MODE_DNS   = 3'd2;
    localparam logic [2:0] MODE_ARP   = 3'd3;
    localparam logic [2:0] MODE_TCP   = 3'd4;
    localparam logic [2:0] MODE_UDP   = 3'd5;
    localparam logic [2:0] MODE_NONE  = 3'd6;

    typedef struct packed {
        logic [7:0]  frame_len;
        logic [15:0] frame_type;
        logic [3:0]  header_words;
        logic [7:0]  next_protocol;
        logic [15:0] source_port;
        logic [15:0] dest_port;
    } frame_fields_t;

    function automatic logic [6:0] l4_start(input logic [15:0] ftype,
                                            input logic [3:0] words);
        logic [6:0] offs;
        if (ftype == TYPE_IPV6)
        begin
            offs = IPV6_L4;
        end
        else
        begin
            offs = ETH_LEN + {1'b0, words, 2'b00};
        end
        return offs;
    endfunction

endpackage
`default_nettype wire

### hdl/epf_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Ethernet protocol filter channel interfaces
// Valid/ready channels for frame bytes, filter results and mode writes.
// ----------------------------------------------------------------------------
interface epf_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface epf_result_if;
    logic valid;
    logic ready;
    logic accept;
    logic truncated;

    modport source (output valid, output accept, output truncated, input ready);
    modport sink (input valid, input accept, input truncated, output ready);
endinterface

interface epf_cfg_if;
    logic       valid;
    logic       ready;
    logic [2:0] filter_mode;

    modport source (output valid, output filter_mode, input ready);
    modport sink (input valid, input filter_mode, output ready);
endinterface
`default_nettype wire

### hdl/epf_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Ethernet protocol filter parser
// Tracks the byte position and captures the EtherType, IHL, protocol and
// layer-4 ports. Presents the fields as they stand after the current item.
// ----------------------------------------------------------------------------
module epf_parser (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  fire,
    input  wire logic [7:0]            data_byte,
    input  wire logic                  last_byte,
    output epf_pkg::frame_fields_t     fields
);

    logic [6:0]  pos_reg, pos_next;
    logic [15:0] ftype_reg, ftype_next;
    logic [3:0]  words_reg, words_next;
    logic [7:0]  proto_reg, proto_next;
    logic [15:0] sport_reg, sport_next;
    logic [15:0] dport_reg, dport_next;
    logic [6:0]  l4;
    logic [6:0]  rel;
    logic        is_ip;
    logic        cap_on;

    always_comb
    begin
        cap_on     = pos_reg != epf_pkg::POS_MAX;
        ftype_next = ftype_reg;
        words_next = words_reg;
        proto_next = proto_reg;
        sport_next = sport_reg;
        dport_next = dport_reg;
        if (cap_on && pos_reg == epf_pkg::POS_TYPE_HI)
        begin
            ftype_next[15:8] = data_byte;
        end
        if (cap_on && pos_reg == epf_pkg::POS_TYPE_LO)
        begin
            ftype_next[7:0] = data_byte;
        end
        if (cap_on && pos_reg == epf_pkg::POS_IHL)
        begin
            words_next = data_byte[3:0];
        end
        if (cap_on && ((ftype_next == epf_pkg::TYPE_IPV4 && pos_reg == epf_pkg::POS_PROTO_V4) ||
                       (ftype_next == epf_pkg::TYPE_IPV6 && pos_reg == epf_pkg::POS_NEXT_V6)))
        begin
            proto_next = data_byte;
        end
        is_ip = ftype_next == epf_pkg::TYPE_IPV4 || ftype_next == epf_pkg::TYPE_IPV6;
        l4    = epf_pkg::l4_start(ftype_next, words_next);
        rel   = pos_reg - l4;
        if (cap_on && is_ip && pos_reg >= epf_pkg::ETH_LEN && pos_reg >= l4 && rel < 7'd4)
        begin
            case (rel[1:0])
                2'd0:    sport_next[15:8] = data_byte;
                2'd1:    sport_next[7:0]  = data_byte;
                2'd2:    dport_next[15:8] = data_byte;
                default: dport_next[7:0]  = data_byte;
            endcase
        end
        if (last_byte)
        begin
            pos_next = '0;
        end
        else if (cap_on)
        begin
            pos_next = pos_reg + 7'd1;
        end
        else
        begin
            pos_next = pos_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            ftype_reg <= '0;
            words_reg <= '0;
            proto_reg <= '0;
            sport_reg <= '0;
            dport_reg <= '0;
        end
        else if (fire)
        begin
            pos_reg <= pos_next;
            if (last_byte)
            begin
                ftype_reg <= '0;
                words_reg <= '0;
                proto_reg <= '0;
                sport_reg <= '0;
                dport_reg <= '0;
            end
            else
            begin
                ftype_reg <= ftype_next;
                words_reg <= words_next;
                proto_reg <= proto_next;
                sport_reg <= sport_next;
                dport_reg <= dport_next;
            end
        end
    end

    assign fields.frame_len     = {1'b0, pos_reg} + 8'd1;
    assign fields.frame_type    = ftype_next;
    assign fields.header_words  = words_next;
    assign fields.next_protocol = proto_next;
    assign fields.source_port   = sport_next;
    assign fields.dest_port     = dport_next;

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        fire && last_byte |=> pos_reg == '0 && ftype_reg == '0 && words_reg == '0)
        else $error("frame state not cleared after the last item");

    a_pos_step: assert property (@(posedge clk) disable iff (!rst_n)
        fire && !last_byte && pos_reg != epf_pkg::POS_MAX |=> pos_reg == $past(pos_reg) + 7'd1)
        else $error("byte position did not advance");

endmodule
`default_nettype wire

### hdl/epf_classify.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Ethernet protocol filter classifier
// Applies the filter mode to the captured fields at the last byte of a
// frame and holds the result in the output register until it is taken.
// ----------------------------------------------------------------------------
module epf_classify (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  decide,
    input  wire logic [2:0]            mode,
    input  wire epf_pkg::frame_fields_t fields,
    input  wire logic                  out_ready,
    output logic                       out_valid,
    output logic                       out_accept,
    output logic                       out_truncated
);

    logic        valid_reg, valid_next;
    logic        accept_reg;
    logic        trunc_reg;
    logic        acc;
    logic        trunc;
    logic        is_ip;
    logic [7:0]  proto_pos;
    logic [7:0]  l4_end;
    logic [7:0]  want;
    logic [15:0] port;
    logic        port_hit;

    always_comb
    begin
        is_ip = fields.frame_type == epf_pkg::TYPE_IPV4 ||
                fields.frame_type == epf_pkg::TYPE_IPV6;
        proto_pos = (fields.frame_type == epf_pkg::TYPE_IPV4) ?
                    {1'b0, epf_pkg::POS_PROTO_V4} : {1'b0, epf_pkg::POS_NEXT_V6};
        l4_end = {1'b0, epf_pkg::l4_start(fields.frame_type, fields.header_words)} + 8'd4;
        want = (mode == epf_pkg::MODE_DNS) ? epf_pkg::PROTO_UDP : epf_pkg::PROTO_TCP;
        case (mode)
            epf_pkg::MODE_HTTP:  port = epf_pkg::PORT_HTTP;
            epf_pkg::MODE_HTTPS: port = epf_pkg::PORT_HTTPS;
            default:             port = epf_pkg::PORT_DNS;
        endcase
        port_hit = fields.source_port == port || fields.dest_port == port;
        acc   = 1'b0;
        trunc = 1'b0;
        case (mode)
            epf_pkg::MODE_NONE:
            begin
                acc = 1'b1;
            end
            epf_pkg::MODE_ARP:
            begin
                if (fields.frame_len < {1'b0, epf_pkg::ETH_LEN})
                begin
                    trunc = 1'b1;
                end
                else
                begin
                    acc = fields.frame_type == epf_pkg::TYPE_ARP;
                end
            end
            epf_pkg::MODE_TCP, epf_pkg::MODE_UDP, epf_pkg::MODE_HTTP,
            epf_pkg::MODE_HTTPS, epf_pkg::MODE_DNS:
            begin
                if (fields.frame_len < {1'b0, epf_pkg::ETH_LEN})
                begin
                    trunc = 1'b1;
                end
                else if (!is_ip)
                begin
                    acc = 1'b0;
                end
                else if (fields.frame_len <= proto_pos)
                begin
                    trunc = 1'b1;
                end
                else if (mode == epf_pkg::MODE_TCP)
                begin
                    acc = fields.next_protocol == epf_pkg::PROTO_TCP;
                end
                else if (mode == epf_pkg::MODE_UDP)
                begin
                    acc = fields.next_protocol == epf_pkg::PROTO_UDP;
                end
                else if (fields.next_protocol != want)
                begin
                    acc = 1'b0;
                end
                else if (fields.frame_len < l4_end)
                begin
                    trunc = 1'b1;
                end
                else
                begin
                    acc = port_hit;
                end
            end
            default:
            begin
                acc = 1'b0;
            end
        endcase
        valid_next = decide | (valid_reg & ~out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (decide)
        begin
            accept_reg <= acc;
            trunc_reg  <= trunc;
        end
    end

    assign out_valid     = valid_reg;
    assign out_accept    = accept_reg;
    assign out_truncated = trunc_reg;

    a_trunc_rejects: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && trunc_reg |-> !accept_reg)
        else $error("truncated frame marked as accepted");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        !(decide && valid_reg && !out_ready))
        else $error("result overwritten before it was taken");

    a_open_mode: assert property (@(posedge clk) disable iff (!rst_n)
        decide && mode == epf_pkg::MODE_NONE |=> valid_reg && accept_reg && !trunc_reg)
        else $error("open filter mode rejected a frame");

endmodule
`default_nettype wire

### hdl/ethernet_protocol_filter_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Ethernet protocol filter
// Classifies an Ethernet frame by EtherType, IP protocol and TCP/UDP port
// as it streams in, and reports one filter result per frame.
//
//   Channel     Dir   Payload                     Moves
//   frame_in    in    data_byte[7:0], last_byte   one frame byte per item
//   result_out  out   accept, truncated           one item per frame
//   cfg         in    filter_mode[2:0]            mode register write
//
// One byte is accepted every cycle unless a last byte is held back. The result
// of a frame appears in the output register in the cycle after its last byte
// is accepted. A last byte waits only while a previous result sits unclaimed
// in the output register; other bytes are never held back.
// Reset clears the frame state and sets the mode to no filter.
// ----------------------------------------------------------------------------
module ethernet_protocol_filter_top (
    input  wire logic   clk,
    input  wire logic   rst_n,
    epf_byte_if.sink    frame_in,
    epf_result_if.source result_out,
    epf_cfg_if.sink     cfg
);

    logic                   fire;
    logic                   decide;
    logic [2:0]             mode_reg;
    epf_pkg::frame_fields_t fields;

    assign frame_in.ready = !frame_in.last_byte || !result_out.valid || result_out.ready;
    assign fire   = frame_in.valid && frame_in.ready;
    assign decide = fire && frame_in.last_byte;
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= epf_pkg::MODE_NONE;
        end
        else if (cfg.valid)
        begin
            mode_reg <= cfg.filter_mode;
        end
    end

    epf_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .data_byte (frame_in.data_byte),
        .last_byte (frame_in.last_byte),
        .fields    (fields)
    );

    epf_classify u_classify (
        .clk           (clk),
        .rst_n         (rst_n),
        .decide        (decide),
        .mode          (mode_reg),
        .fields        (fields),
        .out_ready     (result_out.ready),
        .out_valid     (result_out.valid),
        .out_accept    (result_out.accept),
        .out_truncated (result_out.truncated)
    );

endmodule
`default_nettype wire
